// ----- hw/rtl/dtsr_pkg.sv -----
package dtsr_pkg;

  // Item modes
  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModeRead  = 2'd1;
  localparam logic [1:0] ModeTemp  = 2'd2;

  // Result status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusReadOnly = 2'd1;
  localparam logic [1:0] StatusBadLen   = 2'd2;
  localparam logic [1:0] StatusRange    = 2'd3;

  // Register pointer values
  localparam logic [2:0] RegCap    = 3'd0;
  localparam logic [2:0] RegConfig = 3'd1;
  localparam logic [2:0] RegUpper  = 3'd2;
  localparam logic [2:0] RegLower  = 3'd3;
  localparam logic [2:0] RegCrit   = 3'd4;
  localparam logic [2:0] RegTemp   = 3'd5;
  localparam logic [2:0] RegManuf  = 3'd6;
  localparam logic [2:0] RegDevice = 3'd7;

  localparam logic [15:0] CapValue    = 16'h00ff;
  localparam logic [15:0] ManufValue  = 16'h0054;
  localparam logic [15:0] DeviceValue = 16'h2200;
  localparam logic [15:0] ResetTemp   = 16'd49712;

  localparam logic [7:0] LenPointerOnly = 8'd1;
  localparam logic [7:0] LenWordWrite   = 8'd3;

  localparam logic signed [17:0] TempMinMc = -18'sd40000;
  localparam logic signed [17:0] TempMaxMc = 18'sd125000;

  // |mC| * 16 / 1000 via reciprocal: floor(x * RecipK >> RecipShift) is
  // exact for x up to 2,000,000.
  localparam int unsigned MagW       = 17;
  localparam int unsigned XW         = MagW + 4;
  localparam int unsigned RecipShift = 30;
  localparam int unsigned ProdW      = 2 * XW;
  localparam int unsigned QuotW      = 12;
  localparam logic [XW-1:0] RecipK   = 21'd1073742;

  typedef struct packed {
    logic load;  // capture the accepted item
    logic exec;  // decode and run the item's main step
    logic enc;   // write encoded temperature
    logic flag;  // recompute trip flags
    logic emit;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic need_flag;  // limit or config stored
    logic temp_go;    // in-range temperature update
  } sts_t;

endpackage

// ----- hw/rtl/dtsr_ctrl.sv -----
module dtsr_ctrl
  import dtsr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExec = 3'd1;
  localparam logic [2:0] StEnc  = 3'd2;
  localparam logic [2:0] StFlag = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        if (sts_i.temp_go) begin
          state_d = StEnc;
        end else if (sts_i.need_flag) begin
          state_d = StFlag;
        end else begin
          state_d = StDone;
        end
      end
      StEnc: begin
        cmd_o.enc = 1'b1;
        state_d   = StFlag;
      end
      StFlag: begin
        cmd_o.flag = 1'b1;
        state_d    = StDone;
      end
      StDone: begin
        // hold the finished item until the output register frees up
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/dtsr_datapath.sv -----
module dtsr_datapath
  import dtsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         write_len_i,
  input  logic [7:0]         pointer_byte_i,
  input  logic [15:0]        data_word_i,
  input  logic signed [17:0] temperature_mc_i,
  output logic [7:0]         read_byte_o,
  output logic [1:0]         status_o
);

  // captured item
  logic [1:0]         mode_q;
  logic [7:0]         len_q;
  logic [2:0]         ptr_q;
  logic [15:0]        data_q;
  logic signed [17:0] mc_q;

  // register file
  logic [15:0] config_q, config_d;
  logic [15:0] upper_q, upper_d;
  logic [15:0] lower_q, lower_d;
  logic [15:0] crit_q, crit_d;
  logic [15:0] temp_q, temp_d;
  logic [2:0]  rptr_q, rptr_d;
  logic        phase_q, phase_d;

  // result and conversion
  logic [7:0]       rb_q, rb_d;
  logic [1:0]       st_q, st_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic             neg_q, neg_d;
  logic [7:0]       read_byte_q;
  logic [1:0]       status_q;

  logic             in_range;
  logic             limit_ptr;
  logic [17:0]      mag_full;
  logic [XW-1:0]    x_val;
  logic [QuotW-1:0] quot;
  logic [12:0]      units;
  logic [15:0]      rd_word;
  logic [2:0]       flags;

  assign in_range  = !(mc_q < TempMinMc) && !(mc_q > TempMaxMc);
  assign limit_ptr = (ptr_q == RegConfig) || (ptr_q == RegUpper) ||
                     (ptr_q == RegLower) || (ptr_q == RegCrit);

  assign sts_o.need_flag = (mode_q == ModeWrite) && (len_q == LenWordWrite) && limit_ptr;
  assign sts_o.temp_go   = (mode_q == ModeTemp) && in_range;

  assign mag_full = mc_q[17] ? (~mc_q + 18'd1) : mc_q;
  assign x_val    = {mag_full[MagW-1:0], 4'b0000};
  assign quot     = prod_q[RecipShift +: QuotW];
  assign units    = neg_q ? (13'd0 - {1'b0, quot}) : {1'b0, quot};

  always_comb begin
    unique case (rptr_q)
      RegCap:    rd_word = CapValue;
      RegConfig: rd_word = config_q;
      RegUpper:  rd_word = upper_q;
      RegLower:  rd_word = lower_q;
      RegCrit:   rd_word = crit_q;
      RegTemp:   rd_word = temp_q;
      RegManuf:  rd_word = ManufValue;
      default:   rd_word = DeviceValue;
    endcase
  end

  // signed 13-bit compares of the low fields
  assign flags[2] = !($signed(temp_q[12:0]) < $signed(crit_q[12:0]));
  assign flags[1] = $signed(temp_q[12:0]) > $signed(upper_q[12:0]);
  assign flags[0] = $signed(temp_q[12:0]) < $signed(lower_q[12:0]);

  always_comb begin
    config_d = config_q;
    upper_d  = upper_q;
    lower_d  = lower_q;
    crit_d   = crit_q;
    temp_d   = temp_q;
    rptr_d   = rptr_q;
    phase_d  = phase_q;
    rb_d     = rb_q;
    st_d     = st_q;
    prod_d   = prod_q;
    neg_d    = neg_q;

    if (cmd_i.exec) begin
      rb_d = 8'd0;
      st_d = StatusOk;
      unique case (mode_q)
        ModeWrite: begin
          if (len_q != 8'd0) begin
            rptr_d  = ptr_q;
            phase_d = 1'b0;
            if (len_q == LenWordWrite) begin
              unique case (ptr_q)
                RegConfig: config_d = data_q;
                RegUpper:  upper_d  = data_q;
                RegLower:  lower_d  = data_q;
                RegCrit:   crit_d   = data_q;
                default:   st_d     = StatusReadOnly;
              endcase
            end else if (len_q != LenPointerOnly) begin
              st_d = StatusBadLen;
            end
          end
        end
        ModeRead: begin
          rb_d    = phase_q ? rd_word[7:0] : rd_word[15:8];
          phase_d = !phase_q;
        end
        ModeTemp: begin
          if (!in_range) begin
            st_d = StatusRange;
          end else begin
            prod_d = ProdW'(x_val * RecipK);
            neg_d  = mc_q[17];
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.enc) begin
      temp_d = {3'b000, units};
    end

    if (cmd_i.flag) begin
      temp_d = {flags, temp_q[12:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      len_q  <= write_len_i;
      ptr_q  <= pointer_byte_i[2:0];
      data_q <= data_word_i;
      mc_q   <= temperature_mc_i;
    end
    rb_q   <= rb_d;
    st_q   <= st_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
    if (cmd_i.emit) begin
      read_byte_q <= rb_q;
      status_q    <= st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      config_q <= 16'd0;
      upper_q  <= 16'd0;
      lower_q  <= 16'd0;
      crit_q   <= 16'd0;
      temp_q   <= ResetTemp;
      rptr_q   <= RegCap;
      phase_q  <= 1'b0;
    end else begin
      config_q <= config_d;
      upper_q  <= upper_d;
      lower_q  <= lower_d;
      crit_q   <= crit_d;
      temp_q   <= temp_d;
      rptr_q   <= rptr_d;
      phase_q  <= phase_d;
    end
  end

  assign read_byte_o = read_byte_q;
  assign status_o    = status_q;

endmodule

// ----- hw/rtl/dimm_temp_sensor_registers.sv -----
// DIMM temperature sensor register file. Each item is a bus write
// transaction, a bus read byte or a temperature update, and yields one result
// (read byte and status). Items run one at a time: a write without a store
// or a read runs the exec step, a limit/config store adds the trip-flag step,
// an in-range temperature update the exec (registered reciprocal multiply for
// the millidegree-to-LSB conversion), encode and trip-flag compare steps. The
// next item is accepted in the cycle after the previous result is loaded into
// the output register, even while that result is still stalled.
module dimm_temp_sensor_registers
  import dtsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         write_len_i,
  input  logic [7:0]         pointer_byte_i,
  input  logic [15:0]        data_word_i,
  input  logic signed [17:0] temperature_mc_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         read_byte_o,
  output logic [1:0]         status_o
);

  cmd_t cmd;
  sts_t sts;

  dtsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dtsr_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (mode_i),
    .write_len_i      (write_len_i),
    .pointer_byte_i   (pointer_byte_i),
    .data_word_i      (data_word_i),
    .temperature_mc_i (temperature_mc_i),
    .read_byte_o      (read_byte_o),
    .status_o         (status_o)
  );

endmodule

// ----- hw/rtl/dtsr_checker.sv -----
module dtsr_checker
  import dtsr_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         mode_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [7:0]         read_byte_o,
  input logic [1:0]         status_o
);

  logic       in_acc, out_acc;
  logic [1:0] cnt_q;
  logic [1:0] mode0_q, mode1_q;  // oldest outstanding item first

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 2'd0;
      mode0_q <= ModeWrite;
      mode1_q <= ModeWrite;
    end else begin
      cnt_q <= cnt_q + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        mode0_q <= (in_acc && cnt_q == 2'd1) ? mode_i : mode1_q;
        if (in_acc && cnt_q == 2'd2) begin
          mode1_q <= mode_i;
        end
      end else if (in_acc) begin
        if (cnt_q == 2'd0) begin
          mode0_q <= mode_i;
        end else begin
          mode1_q <= mode_i;
        end
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_byte_o) && $stable(status_o))
    else $error("stalled result changed");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> cnt_q < 2'd2 && !(cnt_q == 2'd1 && !out_valid_o))
    else $error("item accepted while another is still in work");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode0_q != ModeRead |-> read_byte_o == 8'd0)
    else $error("nonzero read byte on non-read item");

  a_status_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (status_o == StatusOk) ||
      (mode0_q == ModeWrite && (status_o == StatusReadOnly || status_o == StatusBadLen)) ||
      (mode0_q == ModeTemp && status_o == StatusRange))
    else $error("status does not match item mode");

  a_valid_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 2'd0)
    else $error("result without an accepted item");

endmodule

bind dimm_temp_sensor_registers dtsr_checker u_dtsr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .mode_i           (mode_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .read_byte_o      (read_byte_o),
  .status_o         (status_o)
);

// ----- sim/testbench.sv -----
module testbench;
  import dtsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam logic [15:0] FlagCrit  = 16'h8000;
  localparam logic [15:0] FlagAbove = 16'h4000;
  localparam logic [15:0] FlagBelow = 16'h2000;
  localparam int unsigned RandomItems = 1500;
  localparam int unsigned LongHoldAt  = 500;
  localparam int unsigned LongHoldLen = 400;

  typedef struct {
    logic [1:0]         mode;
    logic [7:0]         len;
    logic [7:0]         ptr_byte;
    logic [15:0]        data;
    logic signed [17:0] temp_mc;
    int unsigned        gap;
    bit                 drain;
  } sensor_item_t;

  typedef struct {
    logic [7:0] rd_byte;
    logic [1:0] status;
  } sensor_result_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i = '0;
  logic [7:0]         write_len_i = '0;
  logic [7:0]         pointer_byte_i = '0;
  logic [15:0]        data_word_i = '0;
  logic signed [17:0] temperature_mc_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         read_byte_o;
  logic [1:0]         status_o;

  dimm_temp_sensor_registers dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .write_len_i      (write_len_i),
    .pointer_byte_i   (pointer_byte_i),
    .data_word_i      (data_word_i),
    .temperature_mc_i (temperature_mc_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_byte_o      (read_byte_o),
    .status_o         (status_o)
  );

  sensor_item_t   pending_items[$];
  sensor_result_t expected_results[$];
  sensor_item_t   cur_item;
  sensor_result_t want;

  // Shadow register file
  logic [15:0] shadow_config;
  logic [15:0] shadow_upper;
  logic [15:0] shadow_lower;
  logic [15:0] shadow_crit;
  logic [15:0] shadow_temp;
  logic [2:0]  shadow_ptr;
  logic        shadow_lowbyte;

  bit          tx_quiet;
  bit          drain_next;
  bit          gap_loaded;
  bit          offer;
  int unsigned tx_wait;
  bit          rx_quiet;
  int unsigned rx_wait;
  int unsigned results_seen;
  int unsigned error_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void refresh_trip_flags();
    logic signed [12:0] t;
    logic [15:0] flags;
    t = shadow_temp[12:0];
    flags = '0;
    if (t >= $signed(shadow_crit[12:0])) flags |= FlagCrit;
    if (t > $signed(shadow_upper[12:0])) flags |= FlagAbove;
    if (t < $signed(shadow_lower[12:0])) flags |= FlagBelow;
    shadow_temp = flags | {3'b000, shadow_temp[12:0]};
  endfunction

  function automatic sensor_result_t predict_sensor(sensor_item_t it);
    sensor_result_t r;
    logic [15:0] word;
    logic signed [31:0] units;
    r.rd_byte = '0;
    r.status = StatusOk;
    case (it.mode)
      ModeWrite: begin
        if (it.len != 0) begin
          shadow_ptr = it.ptr_byte[2:0];
          shadow_lowbyte = 1'b0;
          if (it.len == LenWordWrite) begin
            case (it.ptr_byte[2:0])
              RegConfig: shadow_config = it.data;
              RegUpper:  shadow_upper = it.data;
              RegLower:  shadow_lower = it.data;
              RegCrit:   shadow_crit = it.data;
              default:   r.status = StatusReadOnly;
            endcase
            if (r.status == StatusOk) refresh_trip_flags();
          end else if (it.len != LenPointerOnly) begin
            r.status = StatusBadLen;
          end
        end
      end
      ModeRead: begin
        case (shadow_ptr)
          RegCap:    word = CapValue;
          RegConfig: word = shadow_config;
          RegUpper:  word = shadow_upper;
          RegLower:  word = shadow_lower;
          RegCrit:   word = shadow_crit;
          RegTemp:   word = shadow_temp;
          RegManuf:  word = ManufValue;
          default:   word = DeviceValue;
        endcase
        r.rd_byte = shadow_lowbyte ? word[7:0] : word[15:8];
        shadow_lowbyte = ~shadow_lowbyte;
      end
      ModeTemp: begin
        if (it.temp_mc < TempMinMc || it.temp_mc > TempMaxMc) begin
          r.status = StatusRange;
        end else begin
          // integer divide truncates toward zero, as the encoding requires
          units = 32'(it.temp_mc) * 16 / 1000;
          shadow_temp = {3'b000, units[12:0]};
          refresh_trip_flags();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_item(input logic [1:0] mode, input logic [7:0] len,
                          input logic [7:0] ptr, input logic [15:0] data,
                          input logic signed [17:0] mc);
    sensor_item_t it;
    it.mode = mode;
    it.len = len;
    it.ptr_byte = ptr;
    it.data = data;
    it.temp_mc = mc;
    it.gap = tx_quiet ? 0 : $urandom_range(0, 14);
    it.drain = drain_next;
    drain_next = 1'b0;
    pending_items.push_back(it);
  endtask

  task automatic write_item(input logic [7:0] len, input logic [7:0] ptr,
                            input logic [15:0] data);
    add_item(ModeWrite, len, ptr, data, 18'($urandom));
  endtask

  task automatic read_item();
    add_item(ModeRead, 8'($urandom), 8'($urandom), 16'($urandom), 18'($urandom));
  endtask

  task automatic temp_item(input logic signed [17:0] mc);
    add_item(ModeTemp, 8'($urandom), 8'($urandom), 16'($urandom), mc);
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait = 0;
      gap_loaded = 1'b0;
      shadow_config = '0;
      shadow_upper = '0;
      shadow_lower = '0;
      shadow_crit = '0;
      shadow_temp = ResetTemp;
      shadow_ptr = '0;
      shadow_lowbyte = 1'b0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_sensor(cur_item));
        offer = 1'b0;
      end
      if (!offer && pending_items.size() > 0) begin
        if (!gap_loaded) begin
          tx_wait = pending_items[0].gap;
          gap_loaded = 1'b1;
        end
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (!pending_items[0].drain || expected_results.size() == 0) begin
          cur_item = pending_items.pop_front();
          gap_loaded = 1'b0;
          offer = 1'b1;
          mode_i <= cur_item.mode;
          write_len_i <= cur_item.len;
          pointer_byte_i <= cur_item.ptr_byte;
          data_word_i <= cur_item.data;
          temperature_mc_i <= cur_item.temp_mc;
        end
      end
      in_valid_i <= offer;
    end
  end

  // Monitor and result check
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
      rx_quiet = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: read_byte %02h status %0d", read_byte_o, status_o);
        end else begin
          want = expected_results.pop_front();
          if (read_byte_o !== want.rd_byte || status_o !== want.status) begin
            error_count++;
            if (error_count <= 10)
              $display("result %0d: expected read_byte %02h status %0d, got %02h %0d",
                       results_seen, want.rd_byte, want.status, read_byte_o, status_o);
          end
        end
        results_seen++;
        if (results_seen % 200 == 0) rx_quiet = ~rx_quiet;
        // one long hold-off so the block backs up and stalls its input
        if (results_seen == LongHoldAt) rx_wait = LongHoldLen;
        else rx_wait = rx_quiet ? 0 : $urandom_range(0, 14);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= (rx_wait > 0);
    end
  end

  initial begin
    int unsigned sel;
    int mc;
    logic [2:0] rsel;
    logic [15:0] word;
    bit drain_marked;

    drain_marked = 1'b0;
    tx_quiet = 1'b0;
    drain_next = 1'b0;

    // directed part
    read_item();
    read_item();
    write_item(8'd0, 8'hff, 16'hffff);
    write_item(LenPointerOnly, {5'h1f, RegTemp}, 16'h0000);
    read_item();
    read_item();
    write_item(LenWordWrite, {5'h00, RegConfig}, 16'hffff);
    write_item(LenWordWrite, {5'h00, RegUpper}, 16'h0000);
    write_item(LenWordWrite, {5'h00, RegLower}, 16'h1fff);
    write_item(LenWordWrite, {5'h00, RegCrit}, 16'h0230);
    write_item(LenWordWrite, {5'h00, RegCap}, 16'h1234);
    write_item(LenWordWrite, {5'h1f, RegTemp}, 16'hffff);
    write_item(LenWordWrite, {5'h0a, RegManuf}, 16'h5555);
    write_item(LenWordWrite, {5'h15, RegDevice}, 16'haaaa);
    write_item(8'd2, {5'h01, RegCrit}, 16'h0000);
    write_item(8'd255, {5'h1e, RegTemp}, 16'hffff);
    temp_item(TempMinMc);
    temp_item(TempMaxMc);
    temp_item(TempMinMc - 18'sd1);
    temp_item(TempMaxMc + 18'sd1);
    temp_item(-18'sd131072);
    temp_item(18'sd131071);
    temp_item(-18'sd63);
    add_item(ModeUnused, 8'hff, 8'hff, 16'hffff, -18'sd1);
    read_item();

    // random part: mostly register transactions, some noise
    while (pending_items.size() < RandomItems) begin
      if ($urandom_range(0, 19) == 0) tx_quiet = ~tx_quiet;
      if (!drain_marked && pending_items.size() >= 750) begin
        drain_marked = 1'b1;
        drain_next = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        rsel = 3'($urandom_range(RegConfig, RegCrit));
        if ($urandom_range(0, 1)) word = {3'($urandom), 13'($urandom_range(0, 2640) - 640)};
        else word = 16'($urandom);
        write_item(LenWordWrite, {5'($urandom), rsel}, word);
        repeat ($urandom_range(0, 3)) read_item();
      end else if (sel < 45) begin
        mc = int'($urandom_range(0, 165000)) - 40000;
        temp_item(18'(mc));
        write_item(LenPointerOnly, {5'($urandom), RegTemp}, 16'($urandom));
        read_item();
        read_item();
      end else if (sel < 65) begin
        write_item(LenPointerOnly, 8'($urandom), 16'($urandom));
        repeat ($urandom_range(1, 4)) read_item();
      end else if (sel < 75) begin
        do rsel = 3'($urandom); while (rsel >= RegConfig && rsel <= RegCrit);
        write_item(LenWordWrite, {5'($urandom), rsel}, 16'($urandom));
      end else begin
        add_item(2'($urandom),
                 $urandom_range(0, 1) ? 8'($urandom_range(0, 4)) : 8'($urandom),
                 8'($urandom), 16'($urandom), 18'($urandom));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) error_count++;

    if (error_count == 0) begin
      $display("PASS dimm_temp_sensor_registers");
    end else begin
      $display("FAIL dimm_temp_sensor_registers");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("FAIL dimm_temp_sensor_registers");
    $finish;
  end

endmodule

// ----- dimm_temp_sensor_registers.f -----
hw/rtl/dtsr_pkg.sv
hw/rtl/dtsr_ctrl.sv
hw/rtl/dtsr_datapath.sv
hw/rtl/dimm_temp_sensor_registers.sv
hw/rtl/dtsr_checker.sv
sim/testbench.sv
